FILE: sv/mcfe_pkg.sv
// shared types and constants of the motor command frame encoder
package mcfe_pkg;

  localparam int VAL_W  = 27;
  localparam int GAIN_W = 26;
  localparam int DIFF_W = 28;
  localparam int MODE_W = 3;
  localparam int CHAN_W = 2;
  localparam int ID_W   = 11;
  localparam int IDX_W  = 3;
  localparam int LANES  = 5;

  localparam logic [MODE_W-1:0] MODE_CONTROL = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ENABLE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DISABLE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ZERO    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PASSIVE = 3'd4;

  localparam logic [IDX_W-1:0] REG_POS_MIN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_POS_MAX   = 3'd1;
  localparam logic [IDX_W-1:0] REG_VEL_MIN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_VEL_MAX   = 3'd3;
  localparam logic [IDX_W-1:0] REG_TRQ_MIN   = 3'd4;
  localparam logic [IDX_W-1:0] REG_TRQ_MAX   = 3'd5;
  localparam logic [IDX_W-1:0] REG_STIFF_MAX = 3'd6;
  localparam logic [IDX_W-1:0] REG_DAMP_MAX  = 3'd7;

  localparam logic [7:0] BYTE_FILL    = 8'hFF;
  localparam logic [7:0] BYTE_ENABLE  = 8'hFC;
  localparam logic [7:0] BYTE_DISABLE = 8'hFD;
  localparam logic [7:0] BYTE_ZERO    = 8'hFE;
  localparam logic [3:0] NIBBLE_MASK  = 4'hF;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAN_W-1:0] channel;
    logic [ID_W-1:0]   id;
  } side_t;

endpackage

FILE: sv/mcfe_if.sv
// handshake channels of the frame encoder: command, frame and register write
interface mcfe_cmd_if import mcfe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [CHAN_W-1:0]       bus_channel;
  logic [ID_W-1:0]         motor_id;
  logic signed [VAL_W-1:0] target_pos;
  logic signed [VAL_W-1:0] target_vel;
  logic signed [VAL_W-1:0] stiff_gain;
  logic signed [VAL_W-1:0] damp_gain;
  logic signed [VAL_W-1:0] ff_torque;
  modport source (output valid, mode, bus_channel, motor_id, target_pos, target_vel,
                  stiff_gain, damp_gain, ff_torque, input ready);
  modport sink (input valid, mode, bus_channel, motor_id, target_pos, target_vel,
                stiff_gain, damp_gain, ff_torque, output ready);
endinterface

interface mcfe_frame_if import mcfe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_channel;
  logic [ID_W-1:0]   frame_id;
  logic [7:0]        byte0;
  logic [7:0]        byte1;
  logic [7:0]        byte2;
  logic [7:0]        byte3;
  logic [7:0]        byte4;
  logic [7:0]        byte5;
  logic [7:0]        byte6;
  logic [7:0]        byte7;
  logic              range_error;
  modport source (output valid, out_channel, frame_id, byte0, byte1, byte2, byte3,
                  byte4, byte5, byte6, byte7, range_error, input ready);
  modport sink (input valid, out_channel, frame_id, byte0, byte1, byte2, byte3,
                byte4, byte5, byte6, byte7, range_error, output ready);
endinterface

interface mcfe_cfg_if import mcfe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [VAL_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/motor_command_frame_encoder_unit.sv
// top level of the motor command frame encoder
// Takes one motor command word on cmd_i and gives one 8-byte standard CAN
// frame word on frame_o, addressed to the command's motor id and channel.
// Register writes arrive on cfg_i and are always taken; write them only
// while no command is in flight.
// Five lanes (position, speed, kp, kd, torque) clamp and scale side by side:
// a clamp stage, a multiply stage, then a long divider with one quotient bit
// per stage, max(POS_BITS, FIELD_BITS) stages; the merge stage packs the
// bytes into the output register.
// Throughput is one command per cycle while cmd_i.ready is high;
// every stage holds one word.
// When the receiver stalls, words collect in the empty stages behind the
// output register and cmd_i.ready drops only once every stage is full.
// Reset empties the pipeline and loads the default ranges.
module motor_command_frame_encoder_unit import mcfe_pkg::*; #(
  parameter int POS_BITS   = 16,
  parameter int FIELD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  mcfe_cmd_if.sink   cmd_i,
  mcfe_cfg_if.sink   cfg_i,
  mcfe_frame_if.source frame_o
);

  localparam int QW = (POS_BITS > FIELD_BITS) ? POS_BITS : FIELD_BITS;
  localparam int S  = QW + 2;
  localparam logic signed [DIFF_W-1:0] KD_PASSIVE = DIFF_W'(2 << FRAC_BITS);

  logic signed [VAL_W-1:0] pos_min_q, pos_max_q, vel_min_q, vel_max_q;
  logic signed [VAL_W-1:0] trq_min_q, trq_max_q;
  logic [GAIN_W-1:0]       stiff_max_q, damp_max_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_min_q   <= -27'sd819200;
      pos_max_q   <= 27'sd819200;
      vel_min_q   <= -27'sd1966080;
      vel_max_q   <= 27'sd1966080;
      trq_min_q   <= -27'sd655360;
      trq_max_q   <= 27'sd655360;
      stiff_max_q <= 26'd32768000;
      damp_max_q  <= 26'd327680;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_POS_MIN:   pos_min_q   <= cfg_i.data;
        REG_POS_MAX:   pos_max_q   <= cfg_i.data;
        REG_VEL_MIN:   vel_min_q   <= cfg_i.data;
        REG_VEL_MAX:   vel_max_q   <= cfg_i.data;
        REG_TRQ_MIN:   trq_min_q   <= cfg_i.data;
        REG_TRQ_MAX:   trq_max_q   <= cfg_i.data;
        REG_STIFF_MAX: stiff_max_q <= cfg_i.data[GAIN_W-1:0];
        REG_DAMP_MAX:  damp_max_q  <= cfg_i.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage occupancy and bubble-collapsing advance chain
  logic [S-1:0] vld_q;
  logic         out_vld_q;
  logic [S:0]   load;

  assign load[S] = !out_vld_q || frame_o.ready;
  for (genvar k = 0; k < S; k++) begin : g_load
    assign load[k] = !vld_q[k] || load[k+1];
  end

  assign cmd_i.ready = load[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (load[0]) begin
        vld_q[0] <= cmd_i.valid;
      end
      for (int k = 1; k < S; k++) begin
        if (load[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (load[S]) begin
        out_vld_q <= vld_q[S-1];
      end
    end
  end

  side_t side_q [S];
  side_t side_in;

  assign side_in = '{mode: cmd_i.mode, channel: cmd_i.bus_channel, id: cmd_i.motor_id};

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      side_q[0] <= side_in;
    end
    for (int k = 1; k < S; k++) begin
      if (load[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // lane operands
  logic passive;
  logic signed [DIFF_W-1:0] val [LANES];
  logic signed [DIFF_W-1:0] lo  [LANES];
  logic signed [DIFF_W-1:0] hi  [LANES];

  assign passive = (cmd_i.mode == MODE_PASSIVE);

  always_comb begin
    val[0] = DIFF_W'(cmd_i.target_pos);
    val[1] = passive ? '0 : DIFF_W'(cmd_i.target_vel);
    val[2] = passive ? '0 : DIFF_W'(cmd_i.stiff_gain);
    val[3] = passive ? KD_PASSIVE : DIFF_W'(cmd_i.damp_gain);
    val[4] = passive ? '0 : DIFF_W'(cmd_i.ff_torque);
    lo[0]  = DIFF_W'(pos_min_q);
    hi[0]  = DIFF_W'(pos_max_q);
    lo[1]  = DIFF_W'(vel_min_q);
    hi[1]  = DIFF_W'(vel_max_q);
    lo[2]  = '0;
    hi[2]  = signed'({2'b00, stiff_max_q});
    lo[3]  = '0;
    hi[3]  = signed'({2'b00, damp_max_q});
    lo[4]  = DIFF_W'(trq_min_q);
    hi[4]  = DIFF_W'(trq_max_q);
  end

  logic [LANES-1:0][QW-1:0] code;
  logic [LANES-1:0]         err;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    mcfe_lane #(
      .QW        (QW),
      .CODE_BITS ((l == 0) ? POS_BITS : FIELD_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .load_i (load[S-1:0]),
      .val_i  (val[l]),
      .lo_i   (lo[l]),
      .hi_i   (hi[l]),
      .code_o (code[l]),
      .err_o  (err[l])
    );
  end

  logic [7:0][7:0] bytes;

  mcfe_merge #(
    .QW (QW)
  ) u_merge (
    .clk_i     (clk_i),
    .load_i    (load[S]),
    .side_i    (side_q[S-1]),
    .code_i    (code),
    .err_i     (err),
    .channel_o (frame_o.out_channel),
    .id_o      (frame_o.frame_id),
    .bytes_o   (bytes),
    .err_o     (frame_o.range_error)
  );

  assign frame_o.valid = out_vld_q;
  assign frame_o.byte0 = bytes[0];
  assign frame_o.byte1 = bytes[1];
  assign frame_o.byte2 = bytes[2];
  assign frame_o.byte3 = bytes[3];
  assign frame_o.byte4 = bytes[4];
  assign frame_o.byte5 = bytes[5];
  assign frame_o.byte6 = bytes[6];
  assign frame_o.byte7 = bytes[7];

endmodule

FILE: sv/mcfe_lane.sv
// one scaling lane: clamp, offset, multiply by full scale, pipelined long division
module mcfe_lane import mcfe_pkg::*; #(
  parameter int QW        = 16,
  parameter int CODE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic [QW+1:0]            load_i,
  input  logic signed [DIFF_W-1:0] val_i,
  input  logic signed [DIFF_W-1:0] lo_i,
  input  logic signed [DIFF_W-1:0] hi_i,
  output logic [QW-1:0]            code_o,
  output logic                     err_o
);

  localparam int NW = DIFF_W + QW;
  localparam logic [QW-1:0] TOP = QW'((2**CODE_BITS) - 1);

  logic signed [DIFF_W-1:0] clamped;
  logic [DIFF_W-1:0]        diff_q, den_a_q, den_b_q;
  logic                     err_a_q, err_b_q;
  logic [NW-1:0]            num_q;

  logic [NW-1:0]     rem_q [QW];
  logic [QW-1:0]     quo_q [QW];
  logic [DIFF_W-1:0] den_q [QW];
  logic              err_q [QW];

  always_comb begin
    if (val_i > hi_i) begin
      clamped = hi_i;
    end else if (val_i < lo_i) begin
      clamped = lo_i;
    end else begin
      clamped = val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      err_a_q <= (hi_i <= lo_i);
      diff_q  <= DIFF_W'(clamped - lo_i);
      den_a_q <= DIFF_W'(hi_i - lo_i);
    end
    if (load_i[1]) begin
      err_b_q <= err_a_q;
      den_b_q <= den_a_q;
      num_q   <= NW'(diff_q) * NW'(TOP);
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [NW-1:0]     rem_in;
    logic [QW-1:0]     quo_in;
    logic [DIFF_W-1:0] den_in;
    logic              err_in;
    logic [NW-1:0]     trial;

    if (j == 0) begin : g_first
      assign rem_in = num_q;
      assign quo_in = '0;
      assign den_in = den_b_q;
      assign err_in = err_b_q;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
      assign err_in = err_q[j-1];
    end

    assign trial = NW'(den_in) << B;

    always_ff @(posedge clk_i) begin
      if (load_i[j+2]) begin
        den_q[j] <= den_in;
        err_q[j] <= err_in;
        if (rem_in >= trial) begin
          rem_q[j] <= rem_in - trial;
          quo_q[j] <= quo_in | (QW'(1) << B);
        end else begin
          rem_q[j] <= rem_in;
          quo_q[j] <= quo_in;
        end
      end
    end
  end

  assign err_o  = err_q[QW-1];
  assign code_o = err_q[QW-1] ? '0 : quo_q[QW-1];

endmodule

FILE: sv/mcfe_merge.sv
// packs lane codes or command bytes into the payload and registers it
module mcfe_merge import mcfe_pkg::*; #(
  parameter int QW = 16
) (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  side_t                 side_i,
  input  logic [LANES-1:0][QW-1:0] code_i,
  input  logic [LANES-1:0]      err_i,
  output logic [CHAN_W-1:0]     channel_o,
  output logic [ID_W-1:0]       id_o,
  output logic [7:0][7:0]       bytes_o,
  output logic                  err_o
);

  logic [15:0]     cp;
  logic [11:0]     cv, ckp, ckd, ct;
  logic [7:0][7:0] bytes_d, bytes_q;
  logic            err_d, err_q;
  logic            is_cmd;
  logic [CHAN_W-1:0] channel_q;
  logic [ID_W-1:0]   id_q;

  assign cp  = 16'(code_i[0]);
  assign cv  = 12'(code_i[1]);
  assign ckp = 12'(code_i[2]);
  assign ckd = 12'(code_i[3]);
  assign ct  = 12'(code_i[4]);

  assign is_cmd = (side_i.mode == MODE_ENABLE) || (side_i.mode == MODE_DISABLE) ||
                  (side_i.mode == MODE_ZERO);

  always_comb begin
    bytes_d = '0;
    err_d   = 1'b0;
    if (is_cmd) begin
      for (int i = 0; i < 7; i++) begin
        bytes_d[i] = BYTE_FILL;
      end
      unique case (side_i.mode)
        MODE_ENABLE:  bytes_d[7] = BYTE_ENABLE;
        MODE_DISABLE: bytes_d[7] = BYTE_DISABLE;
        default:      bytes_d[7] = BYTE_ZERO;
      endcase
    end else begin
      bytes_d[0] = cp[15:8];
      bytes_d[1] = cp[7:0];
      bytes_d[2] = cv[11:4];
      bytes_d[3] = {cv[3:0] & NIBBLE_MASK, ckp[11:8]};
      bytes_d[4] = ckp[7:0];
      bytes_d[5] = ckd[11:4];
      bytes_d[6] = {ckd[3:0] & NIBBLE_MASK, ct[11:8]};
      bytes_d[7] = ct[7:0];
      err_d      = |err_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q   <= bytes_d;
      err_q     <= err_d;
      channel_q <= side_i.channel;
      id_q      <= side_i.id;
    end
  end

  assign bytes_o   = bytes_q;
  assign err_o     = err_q;
  assign channel_o = channel_q;
  assign id_o      = id_q;

endmodule

FILE: bench/mcfe_frame_checker.sv
// frame checker: predicts each frame from accepted commands and compares
module mcfe_frame_checker import mcfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcfe_cmd_if.sink    cmd_i,
  mcfe_cfg_if.sink    cfg_i,
  mcfe_frame_if.sink  frame_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [ID_W-1:0]   id;
    logic [63:0]       payload;
    logic              err;
  } frame_t;

  frame_t frames_due[$];
  longint p_lo, p_hi, v_lo, v_hi, t_lo, t_hi, kp_hi, kd_hi;

  function automatic longint sx(logic [VAL_W-1:0] x);
    return longint'(signed'(x));
  endfunction

  function automatic longint code_of(longint v, longint lo, longint hi, int bits,
                                     ref logic err);
    longint top;
    top = (64'sd1 << bits) - 1;
    if (hi <= lo) begin
      err = 1'b1;
      return 0;
    end
    if (v > hi) v = hi;
    else if (v < lo) v = lo;
    return ((v - lo) * top) / (hi - lo);
  endfunction

  function automatic frame_t encode_frame(logic [MODE_W-1:0] mode, logic [CHAN_W-1:0] ch,
      logic [ID_W-1:0] id, longint p, longint v, longint kp, longint kd, longint t);
    frame_t f;
    logic e;
    logic [15:0] cp;
    logic [11:0] cv, ckp, ckd, ct;
    e = 1'b0;
    f.chan = ch;
    f.id = id;
    if (mode == MODE_ENABLE || mode == MODE_DISABLE || mode == MODE_ZERO) begin
      f.payload = {{7{BYTE_FILL}}, (mode == MODE_ENABLE) ? BYTE_ENABLE :
                   (mode == MODE_DISABLE) ? BYTE_DISABLE : BYTE_ZERO};
    end else begin
      if (mode == MODE_PASSIVE) begin
        v = 0; kp = 0; kd = 2 <<< 16; t = 0;
      end
      cp  = 16'(code_of(p, p_lo, p_hi, 16, e));
      cv  = 12'(code_of(v, v_lo, v_hi, 12, e));
      ckp = 12'(code_of(kp, 0, kp_hi, 12, e));
      ckd = 12'(code_of(kd, 0, kd_hi, 12, e));
      ct  = 12'(code_of(t, t_lo, t_hi, 12, e));
      f.payload = {cp, cv, ckp, ckd, ct};
    end
    f.err = e;
    return f;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t w;
    frame_t g;
    if (!rst_ni) begin
      p_lo = -819200; p_hi = 819200; v_lo = -1966080; v_hi = 1966080;
      t_lo = -655360; t_hi = 655360; kp_hi = 32768000; kd_hi = 327680;
    end else begin
      if (frame_i.valid && frame_i.ready) begin
        g.chan = frame_i.out_channel;
        g.id = frame_i.frame_id;
        g.payload = {frame_i.byte0, frame_i.byte1, frame_i.byte2, frame_i.byte3,
                     frame_i.byte4, frame_i.byte5, frame_i.byte6, frame_i.byte7};
        g.err = frame_i.range_error;
        if (frames_due.size() == 0) begin
          report_mismatch("unexpected frame", g.payload, 0);
        end else begin
          w = frames_due.pop_front();
          if (g.chan !== w.chan) report_mismatch("out_channel", g.chan, w.chan);
          if (g.id !== w.id) report_mismatch("frame_id", g.id, w.id);
          for (int b = 0; b < 8; b++)
            if (g.payload[63-8*b -: 8] !== w.payload[63-8*b -: 8])
              report_mismatch($sformatf("byte%0d", b), g.payload[63-8*b -: 8],
                              w.payload[63-8*b -: 8]);
          if (g.err !== w.err) report_mismatch("range_error", g.err, w.err);
        end
      end
      if (cmd_i.valid && cmd_i.ready)
        frames_due.push_back(encode_frame(cmd_i.mode, cmd_i.bus_channel, cmd_i.motor_id,
            sx(cmd_i.target_pos), sx(cmd_i.target_vel), sx(cmd_i.stiff_gain),
            sx(cmd_i.damp_gain), sx(cmd_i.ff_torque)));
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_POS_MIN:   p_lo = sx(cfg_i.data);
          REG_POS_MAX:   p_hi = sx(cfg_i.data);
          REG_VEL_MIN:   v_lo = sx(cfg_i.data);
          REG_VEL_MAX:   v_hi = sx(cfg_i.data);
          REG_TRQ_MIN:   t_lo = sx(cfg_i.data);
          REG_TRQ_MAX:   t_hi = sx(cfg_i.data);
          REG_STIFF_MAX: kp_hi = longint'(cfg_i.data[GAIN_W-1:0]);
          REG_DAMP_MAX:  kd_hi = longint'(cfg_i.data[GAIN_W-1:0]);
          default: ;
        endcase
      end
      pending_o = frames_due.size();
    end
  end

endmodule

FILE: bench/tb_motor_command_frame_encoder_unit.sv
// testbench top: command and register stimulus, stalls and verdict
module tb_motor_command_frame_encoder_unit import mcfe_pkg::*; ();

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, quiet_cycles;
  int   send_idle_pct, recv_idle_pct, hold_cycles;

  mcfe_cmd_if   cmd ();
  mcfe_cfg_if   cfg ();
  mcfe_frame_if frame ();

  motor_command_frame_encoder_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .cfg_i(cfg), .frame_o(frame)
  );

  mcfe_frame_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .cfg_i(cfg), .frame_i(frame),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cmd.valid = 1'b0; cmd.mode = '0; cmd.bus_channel = '0; cmd.motor_id = '0;
    cmd.target_pos = '0; cmd.target_vel = '0; cmd.stiff_gain = '0;
    cmd.damp_gain = '0; cmd.ff_torque = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    frame.ready = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (!rst_ni) frame.ready <= 1'b0;
    else if (hold_cycles > 0) begin
      frame.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else frame.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (cmd.valid && cmd.ready || frame.valid && frame.ready || cfg.valid && cfg.ready)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb_motor_command_frame_encoder_unit: FAIL");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] rand_val(int flavour);
    logic [VAL_W-1:0] r;
    r = VAL_W'($urandom);
    case (flavour)
      0: r = {1'b0, {(VAL_W-1){1'b1}}};
      1: r = {1'b1, {(VAL_W-1){1'b0}}};
      2: r = VAL_W'($signed($urandom_range(4000000)) - 2000000);
      3: r = VAL_W'($signed($urandom_range(40000000)) - 20000000);
      default: ;
    endcase
    return r;
  endfunction

  // valid stays up after acceptance so that words can follow back to back
  task automatic send_cmd(logic [MODE_W-1:0] m, logic [VAL_W-1:0] p, logic [VAL_W-1:0] v,
                          logic [VAL_W-1:0] kp, logic [VAL_W-1:0] kd, logic [VAL_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd.valid <= 1'b1; cmd.mode <= m; cmd.bus_channel <= CHAN_W'($urandom);
    cmd.motor_id <= ID_W'($urandom); cmd.target_pos <= p; cmd.target_vel <= v;
    cmd.stiff_gain <= kp; cmd.damp_gain <= kd; cmd.ff_torque <= t;
    @(posedge clk_i iff cmd.ready);
  endtask

  task automatic rand_cmd();
    logic [MODE_W-1:0] m;
    m = ($urandom_range(9) == 0) ? MODE_W'($urandom_range(7)) :
        ($urandom_range(1) ? MODE_CONTROL : MODE_PASSIVE);
    send_cmd(m, rand_val($urandom_range(6)), rand_val($urandom_range(6)),
             rand_val($urandom_range(6)), rand_val($urandom_range(6)),
             rand_val($urandom_range(6)));
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] d);
    cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= d;
    @(posedge clk_i iff cfg.ready);
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // one register setting: either extremes, an empty range or moderate values
  task automatic load_ranges(int kind);
    logic [VAL_W-1:0] lo, hi;
    for (int r = 0; r < 3; r++) begin
      case (kind)
        0: begin lo = {1'b1, {(VAL_W-1){1'b0}}}; hi = {1'b0, {(VAL_W-1){1'b1}}}; end
        1: begin lo = VAL_W'(5); hi = VAL_W'(5 - r); end
        default: begin
          lo = VAL_W'(-$signed($urandom_range(3000000)));
          hi = VAL_W'($urandom_range(3000000) + ($urandom_range(3) == 0 ? 0 : 1));
        end
      endcase
      write_reg(IDX_W'(2*r), lo);
      write_reg(IDX_W'(2*r+1), hi);
    end
    case (kind)
      0: begin
        write_reg(REG_STIFF_MAX, {1'b0, {GAIN_W{1'b1}}});
        write_reg(REG_DAMP_MAX, {1'b1, {GAIN_W{1'b1}}});
      end
      1: begin
        write_reg(REG_STIFF_MAX, '0);
        write_reg(REG_DAMP_MAX, '0);
      end
      default: begin
        write_reg(REG_STIFF_MAX, VAL_W'($urandom_range(40000000)));
        write_reg(REG_DAMP_MAX, VAL_W'($urandom_range(600000)) | {1'b1, 26'd0});
      end
    endcase
    cfg.valid <= 1'b0;
  endtask

  initial begin
    send_idle_pct = 0; recv_idle_pct = 0; hold_cycles = 0; quiet_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every mode, field extremes, bounds at reset ranges
    for (int m = 0; m < 8; m++)
      send_cmd(MODE_W'(m), rand_val(2), rand_val(2), rand_val(3), rand_val(2), rand_val(2));
    send_cmd(MODE_CONTROL, rand_val(0), rand_val(0), rand_val(0), rand_val(0), rand_val(0));
    send_cmd(MODE_CONTROL, rand_val(1), rand_val(1), rand_val(1), rand_val(1), rand_val(1));
    send_cmd(MODE_CONTROL, VAL_W'(-819200), VAL_W'(-1966080), '0, '0, VAL_W'(-655360));
    send_cmd(MODE_CONTROL, VAL_W'(819200), VAL_W'(1966080), VAL_W'(32768000),
             VAL_W'(327680), VAL_W'(655360));
    send_cmd(MODE_CONTROL, '0, '0, '0, '0, '0);
    send_cmd(MODE_PASSIVE, rand_val(0), rand_val(0), rand_val(0), rand_val(0), rand_val(0));
    drain();
    load_ranges(1);
    send_cmd(MODE_CONTROL, rand_val(4), rand_val(4), rand_val(4), rand_val(4), rand_val(4));
    send_cmd(MODE_PASSIVE, rand_val(4), '0, '0, '0, '0);
    send_cmd(MODE_ENABLE, '0, '0, '0, '0, '0);
    drain();
    load_ranges(0);
    send_cmd(MODE_CONTROL, rand_val(0), rand_val(0), rand_val(0), rand_val(0), rand_val(0));
    send_cmd(MODE_CONTROL, rand_val(1), rand_val(1), rand_val(1), rand_val(1), rand_val(1));
    send_cmd(MODE_PASSIVE, rand_val(4), '0, '0, '0, '0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 60 : 0;
      recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 26 : 0;
      for (int s = 0; s < 4; s++) begin
        load_ranges((s == 0 && phase == 2) ? 0 : (s == 3 && phase == 1) ? 1 : 2);
        if (phase == 2 && s == 1) hold_cycles = 200;
        for (int k = 0; k < 95; k++) begin
          // no-idle stretch inside the random phases
          if (k == 40 && phase != 2) begin
            send_idle_pct = 0;
          end
          rand_cmd();
        end
        send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 60 : 0;
        // sender waits for every frame before the next setting
        drain();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("tb_motor_command_frame_encoder_unit: PASS");
    end else begin
      $display("tb_motor_command_frame_encoder_unit: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/mcfe_pkg.sv
sv/mcfe_if.sv
sv/mcfe_lane.sv
sv/mcfe_merge.sv
sv/motor_command_frame_encoder_unit.sv
bench/mcfe_frame_checker.sv
bench/tb_motor_command_frame_encoder_unit.sv
